// ===== sv/assert_macros.svh =====
// Assertion helpers for the RTL files.
// Both macros expect a clock named clk in scope; ASSERT_CLK also expects a reset named rst.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Checked property, ignored while reset is high.
`define ASSERT_CLK(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");
// Checked property, also evaluated during reset.
`define ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("assertion failed");
`else
`define ASSERT_CLK(lbl, prop)
`define ASSERT_ALWAYS(lbl, prop)
`endif
`endif

// ===== sv/rne_pkg.sv =====
package rne_pkg;

  // Smallest positive value that has no numeral.
  localparam logic [31:0] TOO_BIG = 32'd4000;

  // Character codes.
  localparam logic [7:0] CH_I    = 8'h69; // i
  localparam logic [7:0] CH_V    = 8'h76; // v
  localparam logic [7:0] CH_X    = 8'h78; // x
  localparam logic [7:0] CH_L    = 8'h6c; // l
  localparam logic [7:0] CH_C    = 8'h63; // c
  localparam logic [7:0] CH_D    = 8'h64; // d
  localparam logic [7:0] CH_M    = 8'h6d; // m
  localparam logic [7:0] CH_STAR = 8'h2a; // *
  localparam logic [7:0] CH_NONE = 8'h00;

  // Decade codes.
  localparam logic [1:0] DEC_ONES      = 2'd0;
  localparam logic [1:0] DEC_TENS      = 2'd1;
  localparam logic [1:0] DEC_HUNDREDS  = 2'd2;
  localparam logic [1:0] DEC_THOUSANDS = 2'd3;

  // Program addresses.
  localparam logic [3:0] PC_IDLE     = 4'd0;
  localparam logic [3:0] PC_CLASSIFY = 4'd1;
  localparam logic [3:0] PC_STAR0    = 4'd2;
  localparam logic [3:0] PC_STAR1    = 4'd3;
  localparam logic [3:0] PC_EXT3     = 4'd4;
  localparam logic [3:0] PC_EMIT3    = 4'd5;
  localparam logic [3:0] PC_EXT2     = 4'd6;
  localparam logic [3:0] PC_EMIT2    = 4'd7;
  localparam logic [3:0] PC_EXT1     = 4'd8;
  localparam logic [3:0] PC_EMIT1    = 4'd9;
  localparam logic [3:0] PC_EXT0     = 4'd10;
  localparam logic [3:0] PC_EMIT0    = 4'd11;

  typedef enum logic [2:0] {
    OP_WAIT,
    OP_CLASSIFY,
    OP_STAR,
    OP_EXTRACT,
    OP_EMIT
  } op_t;

  // Letter role within a decade: unit, five, next unit.
  typedef enum logic [1:0] {
    SYM_U,
    SYM_F,
    SYM_N
  } sym_t;

  // One control word of the program.
  typedef struct packed {
    op_t        op;
    logic [1:0] decade;
    logic       fin;   // last flag for star steps
    logic [3:0] next;  // sequential or taken target
    logic [3:0] alt;   // alternate target
  } ucw_t;

  // Program ROM.
  function automatic ucw_t ucode(input logic [3:0] pc);
    ucw_t w;
    w = '{op: OP_WAIT, decade: DEC_ONES, fin: 1'b0, next: PC_CLASSIFY, alt: PC_IDLE};
    case (pc)
      PC_IDLE:     w = '{op: OP_WAIT, decade: DEC_ONES, fin: 1'b0,
                         next: PC_CLASSIFY, alt: PC_IDLE};
      PC_CLASSIFY: w = '{op: OP_CLASSIFY, decade: DEC_ONES, fin: 1'b0,
                         next: PC_EXT3, alt: PC_STAR0};
      PC_STAR0:    w = '{op: OP_STAR, decade: DEC_ONES, fin: 1'b0,
                         next: PC_STAR1, alt: PC_IDLE};
      PC_STAR1:    w = '{op: OP_STAR, decade: DEC_ONES, fin: 1'b1,
                         next: PC_IDLE, alt: PC_IDLE};
      PC_EXT3:     w = '{op: OP_EXTRACT, decade: DEC_THOUSANDS, fin: 1'b0,
                         next: PC_EMIT3, alt: PC_EXT2};
      PC_EMIT3:    w = '{op: OP_EMIT, decade: DEC_THOUSANDS, fin: 1'b0,
                         next: PC_IDLE, alt: PC_EXT2};
      PC_EXT2:     w = '{op: OP_EXTRACT, decade: DEC_HUNDREDS, fin: 1'b0,
                         next: PC_EMIT2, alt: PC_EXT1};
      PC_EMIT2:    w = '{op: OP_EMIT, decade: DEC_HUNDREDS, fin: 1'b0,
                         next: PC_IDLE, alt: PC_EXT1};
      PC_EXT1:     w = '{op: OP_EXTRACT, decade: DEC_TENS, fin: 1'b0,
                         next: PC_EMIT1, alt: PC_EXT0};
      PC_EMIT1:    w = '{op: OP_EMIT, decade: DEC_TENS, fin: 1'b0,
                         next: PC_IDLE, alt: PC_EXT0};
      PC_EXT0:     w = '{op: OP_EXTRACT, decade: DEC_ONES, fin: 1'b0,
                         next: PC_EMIT0, alt: PC_IDLE};
      PC_EMIT0:    w = '{op: OP_EMIT, decade: DEC_ONES, fin: 1'b0,
                         next: PC_IDLE, alt: PC_IDLE};
      default:     w = '{op: OP_WAIT, decade: DEC_ONES, fin: 1'b0,
                         next: PC_CLASSIFY, alt: PC_IDLE};
    endcase
    return w;
  endfunction

  // Weight of one step in a decade.
  function automatic logic [13:0] decade_scale(input logic [1:0] decade);
    logic [13:0] s;
    unique case (decade)
      DEC_ONES:      s = 14'd1;
      DEC_TENS:      s = 14'd10;
      DEC_HUNDREDS:  s = 14'd100;
      DEC_THOUSANDS: s = 14'd1000;
      default:       s = 14'd1;
    endcase
    return s;
  endfunction

  // Number of letters that a digit expands to.
  function automatic logic [2:0] pat_len(input logic [3:0] d);
    logic [2:0] n;
    case (d) inside
      4'd1, 4'd5:       n = 3'd1;
      4'd2, 4'd4, 4'd6: n = 3'd2;
      4'd9:             n = 3'd2;
      4'd3, 4'd7:       n = 3'd3;
      4'd8:             n = 3'd4;
      default:          n = 3'd0;
    endcase
    return n;
  endfunction

  // Letter role at position p of a digit's expansion.
  function automatic sym_t pat_sym(input logic [3:0] d, input logic [1:0] p);
    sym_t s;
    s = SYM_U;
    if (d == 4'd4 && p == 2'd1) begin
      s = SYM_F;
    end else if (d == 4'd9 && p == 2'd1) begin
      s = SYM_N;
    end else if (d >= 4'd5 && d <= 4'd8 && p == 2'd0) begin
      s = SYM_F;
    end
    return s;
  endfunction

  // Letter for a role in a decade.
  function automatic logic [7:0] letter(input logic [1:0] decade, input sym_t s);
    logic [7:0] c;
    c = CH_STAR;
    unique case (s)
      SYM_U: begin
        case (decade)
          DEC_ONES:      c = CH_I;
          DEC_TENS:      c = CH_X;
          DEC_HUNDREDS:  c = CH_C;
          default:       c = CH_M;
        endcase
      end
      SYM_F: begin
        case (decade)
          DEC_ONES:      c = CH_V;
          DEC_TENS:      c = CH_L;
          DEC_HUNDREDS:  c = CH_D;
          default:       c = CH_STAR;
        endcase
      end
      SYM_N: begin
        case (decade)
          DEC_ONES:      c = CH_X;
          DEC_TENS:      c = CH_C;
          DEC_HUNDREDS:  c = CH_M;
          default:       c = CH_STAR;
        endcase
      end
      default: c = CH_STAR;
    endcase
    return c;
  endfunction

endpackage

// ===== sv/roman_numeral_encoder.sv =====
// Channel | Dir | Signals                          | Contents
// s       | in  | s_tvalid s_tready s_tdata[31:0]  | value (signed)
// m       | out | m_tvalid m_tready m_tdata[7:0]   | ch
//         |     | m_tlast m_tuser[0]               | last, empty_res
//
// A microcoded sequencer issues one control word per cycle. An item passes
// through an accept step and a classify step, then one extract step per decade
// examined (up to 4) and one emit step per character (up to 15); an empty result
// is sent from the classify step, an overflow as two star characters.
// Reset (rst, synchronous) returns the step counter to the wait step and
// drops m_tvalid. A stall on m_tready holds the sequencer on its step.
`include "assert_macros.svh"

module roman_numeral_encoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] value
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [7:0] ch
  output logic        m_tlast,
  output logic        m_tuser    // [0] empty_res
);

  // Sequencer and datapath registers.
  logic [3:0]  pc;
  logic [11:0] rem;
  logic [3:0]  digit;
  logic [1:0]  pos;
  logic        is_empty;
  logic        is_big;

  rne_pkg::ucw_t uw;
  logic          out_free;
  logic          out_load;
  logic          s_acc;

  // Digit extraction.
  logic [13:0] scale;
  logic [13:0] thr;
  logic [13:0] thr_k;
  logic [3:0]  d_ext;

  // Character emission.
  rne_pkg::sym_t sym;
  logic [7:0]    emit_ch;
  logic          pat_done;

  assign uw       = rne_pkg::ucode(pc);
  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (uw.op == rne_pkg::OP_WAIT);
  assign s_acc    = s_tvalid && s_tready;

  // A new item enters the output register on every emitting step that is not stalled.
  assign out_load = out_free && (((uw.op == rne_pkg::OP_CLASSIFY) && is_empty) ||
                                 (uw.op == rne_pkg::OP_STAR) ||
                                 (uw.op == rne_pkg::OP_EMIT));

  // Find the largest multiple of the decade weight that fits the remainder.
  always_comb begin
    scale = rne_pkg::decade_scale(uw.decade);
    thr   = 14'd0;
    d_ext = 4'd0;
    thr_k = 14'd0;
    for (int k = 1; k <= 9; k++) begin
      thr_k = scale * 14'(k);
      if ({2'b00, rem} >= thr_k) begin
        thr   = thr_k;
        d_ext = 4'(k);
      end
    end
  end

  // Current letter of the digit's expansion.
  assign sym      = rne_pkg::pat_sym(digit, pos);
  assign emit_ch  = rne_pkg::letter(uw.decade, sym);
  assign pat_done = (({1'b0, pos} + 3'd1) == rne_pkg::pat_len(digit));

  // Sequencer step and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      pc       <= rne_pkg::PC_IDLE;
      rem      <= 12'd0;
      m_tvalid <= 1'b0;
    end else begin
      // The output holds its item until the receiver takes it.
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (uw.op)
        rne_pkg::OP_WAIT: begin
          if (s_acc) begin
            is_empty <= (s_tdata == 32'd0) || s_tdata[31];
            is_big   <= !s_tdata[31] && (s_tdata >= rne_pkg::TOO_BIG);
            rem      <= (!s_tdata[31] && (s_tdata < rne_pkg::TOO_BIG)) ?
                        s_tdata[11:0] : 12'd0;
            pc       <= uw.next;
          end
        end
        rne_pkg::OP_CLASSIFY: begin
          if (is_empty) begin
            if (out_free) begin
              m_tdata  <= rne_pkg::CH_NONE;
              m_tlast  <= 1'b1;
              m_tuser  <= 1'b1;
              pc       <= rne_pkg::PC_IDLE;
            end
          end else if (is_big) begin
            pc <= uw.alt;
          end else begin
            pc <= uw.next;
          end
        end
        rne_pkg::OP_STAR: begin
          if (out_free) begin
            m_tdata  <= rne_pkg::CH_STAR;
            m_tlast  <= uw.fin;
            m_tuser  <= 1'b0;
            pc       <= uw.next;
          end
        end
        rne_pkg::OP_EXTRACT: begin
          digit <= d_ext;
          rem   <= rem - thr[11:0];
          pos   <= 2'd0;
          pc    <= (d_ext == 4'd0) ? uw.alt : uw.next;
        end
        rne_pkg::OP_EMIT: begin
          if (out_free) begin
            m_tdata  <= emit_ch;
            m_tlast  <= pat_done && (rem == 12'd0);
            m_tuser  <= 1'b0;
            if (pat_done) begin
              pos <= 2'd0;
              pc  <= (rem == 12'd0) ? uw.next : uw.alt;
            end else begin
              pos <= pos + 2'd1;
            end
          end
        end
        default: pc <= rne_pkg::PC_IDLE;
      endcase
    end
  end

  // An accepted item keeps the input closed on the next cycle.
  `ASSERT_CLK(a_busy_after_accept, s_acc |=> !s_tready)
  // An empty result is always a one-character run with a zero code.
  `ASSERT_CLK(a_empty_is_last, (m_tvalid && m_tuser) |-> (m_tlast && m_tdata == 8'd0))
  // The remainder stays in the range that has a numeral.
  `ASSERT_CLK(a_rem_range, rem < 12'd4000)
  // Emitting never runs past the digit's expansion.
  `ASSERT_CLK(a_pos_range, (uw.op == rne_pkg::OP_EMIT) |-> ({1'b0, pos} < rne_pkg::pat_len(digit)))

endmodule
